>>> rtl/nth_pkg.sv
`default_nettype none
package nth_pkg;

    localparam int Q_BITS       = 30;
    localparam int GUARD        = 30;
    localparam int CORDIC_STEPS = 31;
    localparam int STEP_W       = 5;
    localparam int ZW           = 33;
    localparam int HEAD_W       = 17;

    localparam longint PI_Q30      = 64'd3373259426;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // atan(2^-i) in Q30; past the table the value is 2^(30-i)
    function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 33'sd843314857;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043837;
            5'd3:    v = 33'sd133525159;
            5'd4:    v = 33'sd67021687;
            5'd5:    v = 33'sd33543516;
            5'd6:    v = 33'sd16775851;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194283;
            5'd9:    v = 33'sd2097149;
            default: v = ZW'(longint'(1) << (Q_BITS - int'(idx)));
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/nth_cordic.sv
`default_nettype none
module nth_cordic
    import nth_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [COORD_BITS-1:0] i_ax,
    input  wire logic [COORD_BITS-1:0] i_ay,
    output logic                       o_done,
    output logic signed [ZW-1:0]       o_theta
);

    localparam int XW = COORD_BITS + GUARD + 3;
    localparam int FS = Q_BITS - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0] RND_HALF  = ZW'(longint'(1) << (FS - 1));

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_RND  = 3'b100
    } t_cstate;

    t_cstate                 r_state, n_state;
    logic signed [XW-1:0]    r_x, r_y;
    logic signed [ZW-1:0]    r_z;
    logic [STEP_W-1:0]       r_i;
    logic signed [ZW-1:0]    r_theta;
    logic                    r_done;

    logic signed [XW-1:0]    w_xs, w_ys;
    logic signed [ZW-1:0]    w_zc;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;

    always_comb begin
        if (r_z < 0) begin
            w_zc = '0;
        end else if (r_z > HALF_PI_Z) begin
            w_zc = HALF_PI_Z;
        end else begin
            w_zc = r_z;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_start) n_state = (i_ay == '0 || i_ax == '0) ? C_RND : C_RUN;
            C_RUN:   if (r_i == STEP_W'(CORDIC_STEPS - 1)) n_state = C_RND;
            C_RND:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    r_x <= XW'({3'b000, i_ax, {GUARD{1'b0}}});
                    r_y <= XW'({3'b000, i_ay, {GUARD{1'b0}}});
                    r_i <= '0;
                    if (i_ay == '0) begin
                        r_z <= '0;
                    end else if (i_ax == '0) begin
                        r_z <= HALF_PI_Z;
                    end else begin
                        r_z <= '0;
                    end
                end
            end
            C_RUN: begin
                if (!r_y[XW-1]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + atan_step(r_i);
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - atan_step(r_i);
                end
                r_i <= r_i + 1'b1;
            end
            C_RND: begin
                r_theta <= (w_zc + RND_HALF) >>> FS;
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_theta = r_theta;

endmodule
`default_nettype wire

>>> rtl/nearest_target_heading_top.sv
`default_nettype none
// Nearest-target heading. Streams neighbour positions with the agent position
// and keeps the neighbour at the smallest squared distance (earliest wins a
// tie). On the item flagged last_nbr it returns the heading toward that
// neighbour in radians scaled by 2^ANGLE_FRAC_BITS, screen y pointing down,
// plus the neighbour position; a target on the agent gives heading 0 and the
// coincident flag. Each neighbour goes through transfer, two passes of the
// shared squaring multiplier and compare. The last neighbour then goes
// through setup, start, 31 iterations of the shared CORDIC add/shift unit,
// rounding, handoff and the output load before the next transfer. A target
// on an axis skips the iterations; a target on the agent skips the CORDIC
// unit. A finished result sits in the output register, and the block takes
// the next run while it waits; a second result stalls the input until the
// first transfer.
module nearest_target_heading_top
    import nth_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [COORD_BITS-1:0]   i_self_x,
    input  wire logic [COORD_BITS-1:0]   i_self_y,
    input  wire logic [COORD_BITS-1:0]   i_nbr_x,
    input  wire logic [COORD_BITS-1:0]   i_nbr_y,
    input  wire logic                    i_last_nbr,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [HEAD_W-1:0]     o_heading,
    output logic [COORD_BITS-1:0]        o_target_x,
    output logic [COORD_BITS-1:0]        o_target_y,
    output logic                         o_coincident
);

    localparam int DW = 2 * COORD_BITS + 1;
    localparam int FS = Q_BITS - ANGLE_FRAC_BITS;
    localparam logic signed [ZW:0] PI_RND =
        (ZW + 1)'((PI_Q30 + (longint'(1) << (FS - 1))) >> FS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQX   = 8'b0000_0010,
        S_SQY   = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_PREP  = 8'b0001_0000,
        S_START = 8'b0010_0000,
        S_ANG   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    logic [COORD_BITS-1:0]   r_sx, r_sy, r_nx, r_ny;
    logic                    r_last;
    logic [COORD_BITS-1:0]   r_dx, r_dy;
    logic [DW-1:0]           r_acc;
    logic [COORD_BITS-1:0]   r_best_x, r_best_y;
    logic [DW-1:0]           r_best_d;
    logic                    r_have;
    logic                    r_up, r_right, r_left, r_coinc;
    logic                    r_out_valid;
    logic signed [HEAD_W-1:0] r_out_head;
    logic [COORD_BITS-1:0]   r_out_x, r_out_y;
    logic                    r_out_coinc;

    logic                    w_accept, w_out_load, w_start, w_cdone;
    logic [COORD_BITS-1:0]   w_op;
    logic [2*COORD_BITS-1:0] w_prod;
    logic signed [ZW-1:0]    w_theta;
    logic signed [ZW:0]      w_th, w_head;

    function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign w_start    = (r_state == S_START) && !r_coinc;

    assign w_op   = (r_state == S_SQX) ? r_dx : r_dy;
    assign w_prod = w_op * w_op;

    nth_cordic #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ax    (r_dx),
        .i_ay    (r_dy),
        .o_done  (w_cdone),
        .o_theta (w_theta)
    );

    assign w_th = {w_theta[ZW-1], w_theta};

    always_comb begin
        if (r_up) begin
            w_head = r_right ? w_th : PI_RND - w_th;
        end else begin
            w_head = r_left ? PI_RND + w_th : -w_th;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_CMP;
            S_CMP:   n_state = r_last ? S_PREP : S_IDLE;
            S_PREP:  n_state = S_START;
            S_START: n_state = r_coinc ? S_OUT : S_ANG;
            S_ANG:   if (w_cdone) n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_d    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CMP && (!r_have || r_acc < r_best_d)) begin
                r_best_x <= r_nx;
                r_best_y <= r_ny;
                r_best_d <= r_acc;
                r_have   <= 1'b1;
            end else if (w_out_load) begin
                r_best_x <= '0;
                r_best_y <= '0;
                r_best_d <= '0;
                r_have   <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sx   <= i_self_x;
            r_sy   <= i_self_y;
            r_nx   <= i_nbr_x;
            r_ny   <= i_nbr_y;
            r_last <= i_last_nbr;
            r_dx   <= absdiff(i_nbr_x, i_self_x);
            r_dy   <= absdiff(i_nbr_y, i_self_y);
        end
        if (r_state == S_SQX) begin
            r_acc <= DW'(w_prod);
        end
        if (r_state == S_SQY) begin
            r_acc <= r_acc + DW'(w_prod);
        end
        if (r_state == S_PREP) begin
            r_dx    <= absdiff(r_best_x, r_sx);
            r_dy    <= absdiff(r_best_y, r_sy);
            r_up    <= (r_best_y < r_sy);
            r_right <= (r_sx < r_best_x);
            r_left  <= (r_sx > r_best_x);
            r_coinc <= (r_best_x == r_sx) && (r_best_y == r_sy);
        end
        if (w_out_load) begin
            r_out_head  <= r_coinc ? '0 : w_head[HEAD_W-1:0];
            r_out_x     <= r_best_x;
            r_out_y     <= r_best_y;
            r_out_coinc <= r_coinc;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_heading    = r_out_head;
    assign o_target_x   = r_out_x;
    assign o_target_y   = r_out_y;
    assign o_coincident = r_out_coinc;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("ready high right after input transfer");

    a_done_in_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> (r_state == S_ANG))
        else $error("angle unit finished outside angle wait");

    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_coincident) |-> (o_heading == '0))
        else $error("coincident result with nonzero heading");

    a_clear_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> !r_have)
        else $error("best neighbour not cleared after result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && o_valid && !i_ready) |=> (r_state == S_OUT))
        else $error("result overwritten while output pending");

endmodule
`default_nettype wire

>>> dv/tb_nearest_target_heading_top.sv
`timescale 1ns / 1ps

module tb_nearest_target_heading_top;
    import nth_pkg::*;

    localparam int CB          = 12;
    localparam int FRAC_BITS   = 13;
    localparam int FRAC_SHIFT  = Q_BITS - FRAC_BITS;
    localparam int RUN_ITEMS   = 175;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int DIR_ROWS    = 23;

    typedef struct packed {
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] nx;
        logic [CB-1:0] ny;
        logic          last;
    } t_nbr_item;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic [CB-1:0]            tx;
        logic [CB-1:0]            ty;
        logic                     coinc;
    } t_heading_res;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [CB-1:0]            i_self_x;
    logic [CB-1:0]            i_self_y;
    logic [CB-1:0]            i_nbr_x;
    logic [CB-1:0]            i_nbr_y;
    logic                     i_last_nbr;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [HEAD_W-1:0] o_heading;
    logic [CB-1:0]            o_target_x;
    logic [CB-1:0]            o_target_y;
    logic                     o_coincident;

    nearest_target_heading_top #(
        .COORD_BITS      (CB),
        .ANGLE_FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_self_x     (i_self_x),
        .i_self_y     (i_self_y),
        .i_nbr_x      (i_nbr_x),
        .i_nbr_y      (i_nbr_y),
        .i_last_nbr   (i_last_nbr),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_heading    (o_heading),
        .o_target_x   (o_target_x),
        .o_target_y   (o_target_y),
        .o_coincident (o_coincident)
    );

    // nearest-neighbor tracking state
    logic [CB-1:0]     near_x;
    logic [CB-1:0]     near_y;
    logic [2*CB:0]     near_dist;
    bit                near_seen;

    t_heading_res      pending_headings[$];
    int                mismatches;
    int                stall_cycles;
    int                src_idle_pct;
    int                sink_idle_pct;
    int                holds_asked;
    int                holds_done;

    // sx sy nx ny last typed heading tx ty coinc
    int dir_tab [DIR_ROWS][10] = '{
        '{   0,    0,    0,    0, 1, 1, 0,    0,    0, 1},
        '{4095, 4095, 4095, 4095, 1, 1, 0, 4095, 4095, 1},
        '{ 100,  100,  200,  100, 1, 1, 0,  200,  100, 0},
        '{ 200,  100,  100,  100, 1, 0, 0,    0,    0, 0},
        '{ 100,  200,  100,  100, 1, 0, 0,    0,    0, 0},
        '{ 100,  100,  100,  200, 1, 0, 0,    0,    0, 0},
        '{   0,    0, 4095, 4095, 1, 0, 0,    0,    0, 0},
        '{4095, 4095,    0,    0, 1, 0, 0,    0,    0, 0},
        '{   0, 4095, 4095,    0, 1, 0, 0,    0,    0, 0},
        '{4095,    0,    0, 4095, 1, 0, 0,    0,    0, 0},
        '{ 500,  500,  510,  500, 0, 0, 0,    0,    0, 0},
        '{ 500,  500,  490,  500, 0, 0, 0,    0,    0, 0},
        '{ 500,  500,  500,  510, 0, 0, 0,    0,    0, 0},
        '{ 500,  500, 3000, 3000, 1, 0, 0,    0,    0, 0},
        '{2048, 2048, 4095,    0, 0, 0, 0,    0,    0, 0},
        '{2048, 2048, 2050, 2047, 0, 0, 0,    0,    0, 0},
        '{2048, 2048, 2049, 2048, 0, 0, 0,    0,    0, 0},
        '{2048, 2048,    0, 4095, 1, 0, 0,    0,    0, 0},
        '{  10,   10,   20,   20, 0, 0, 0,    0,    0, 0},
        '{  30,   30,   25,   25, 0, 0, 0,    0,    0, 0},
        '{1000, 1000, 4000,  100, 1, 0, 0,    0,    0, 0},
        '{   7,    9,    8,    9, 0, 0, 0,    0,    0, 0},
        '{   7,    9,    7,    9, 1, 1, 0,    7,    9, 1}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint atan_q30(input int i);
        case (i)
            0:       return 843314857;
            1:       return 497837829;
            2:       return 263043837;
            3:       return 133525159;
            4:       return 67021687;
            5:       return 33543516;
            6:       return 16775851;
            7:       return 8388437;
            8:       return 4194283;
            9:       return 2097149;
            default: return longint'(1) << (Q_BITS - i);
        endcase
    endfunction

    // vectoring rotation, angle of (ax, ay) in Q30, clamped to [0, pi/2]
    function automatic longint base_angle_q30(input longint ax, input longint ay);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        if (ay == 0)
            return 0;
        if (ax == 0)
            return HALF_PI_Q30;
        x = ax <<< GUARD;
        y = ay <<< GUARD;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q30(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q30(i);
            end
        end
        if (z < 0)
            z = 0;
        if (z > HALF_PI_Q30)
            z = HALF_PI_Q30;
        return z;
    endfunction

    function automatic longint round_angle(input longint v);
        return (v + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    endfunction

    function automatic longint abs_diff(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // returns 1 when the item closes a run; r then holds the heading
    function automatic bit update_nearest(input t_nbr_item it, output t_heading_res r);
        longint dx;
        longint dy;
        longint th;
        longint pi_r;
        longint h;
        logic [2*CB:0] d;
        r = '0;
        dx = abs_diff(longint'(it.nx), longint'(it.sx));
        dy = abs_diff(longint'(it.ny), longint'(it.sy));
        d = (2 * CB + 1)'(dx * dx + dy * dy);
        if (!near_seen || d < near_dist) begin
            near_x    = it.nx;
            near_y    = it.ny;
            near_dist = d;
            near_seen = 1'b1;
        end
        if (!it.last)
            return 1'b0;
        dx = abs_diff(longint'(near_x), longint'(it.sx));
        dy = abs_diff(longint'(near_y), longint'(it.sy));
        h = 0;
        if (dx == 0 && dy == 0) begin
            r.coinc = 1'b1;
        end else begin
            th   = round_angle(base_angle_q30(dx, dy));
            pi_r = round_angle(PI_Q30);
            if (near_y < it.sy)
                h = (it.sx < near_x) ? th : pi_r - th;
            else
                h = (it.sx > near_x) ? pi_r + th : -th;
        end
        r.heading = h[HEAD_W-1:0];
        r.tx      = near_x;
        r.ty      = near_y;
        near_x    = '0;
        near_y    = '0;
        near_dist = '0;
        near_seen = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CB'($urandom_range(4095));
        endcase
    endfunction

    // often at or near the given point so that ties, axes and coincidence occur
    function automatic logic [CB-1:0] near_coord(input logic [CB-1:0] c);
        int v;
        case ($urandom_range(9))
            0:       return c;
            1:       return '0;
            2:       return '1;
            3, 4, 5: begin
                v = int'(c) + $urandom_range(16) - 8;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                return CB'(v);
            end
            default: return CB'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_neighbor(input t_nbr_item it, input bit typed,
                                 input t_heading_res typed_res);
        t_heading_res r;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_self_x   <= it.sx;
        i_self_y   <= it.sy;
        i_nbr_x    <= it.nx;
        i_nbr_y    <= it.ny;
        i_last_nbr <= it.last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (update_nearest(it, r))
            pending_headings.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    task automatic send_random_run(output int n);
        t_nbr_item    it;
        t_heading_res no_res;
        int           len;
        bit           drift;
        logic [CB-1:0] ax;
        logic [CB-1:0] ay;
        no_res = '0;
        len    = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        drift  = ($urandom_range(9) == 0);
        ax     = rand_coord();
        ay     = rand_coord();
        for (int j = 0; j < len; j++) begin
            if (drift) begin
                ax = near_coord(ax);
                ay = near_coord(ay);
            end
            it.sx   = ax;
            it.sy   = ay;
            it.nx   = near_coord(ax);
            it.ny   = near_coord(ay);
            it.last = (j == len - 1);
            send_neighbor(it, 1'b0, no_res);
        end
        n = len;
    endtask

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_heading_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_headings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: heading %0d target (%0d,%0d) coinc %0b",
                         $time, o_heading, o_target_x, o_target_y, o_coincident);
            end else begin
                e = pending_headings.pop_front();
                if (o_heading !== e.heading) begin
                    mismatches++;
                    $display("%0t: heading expected %0d actual %0d",
                             $time, e.heading, o_heading);
                end
                if (o_target_x !== e.tx) begin
                    mismatches++;
                    $display("%0t: target_x expected %0d actual %0d",
                             $time, e.tx, o_target_x);
                end
                if (o_target_y !== e.ty) begin
                    mismatches++;
                    $display("%0t: target_y expected %0d actual %0d",
                             $time, e.ty, o_target_y);
                end
                if (o_coincident !== e.coinc) begin
                    mismatches++;
                    $display("%0t: coincident expected %0b actual %0b",
                             $time, e.coinc, o_coincident);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_nbr_item    it;
        t_heading_res tr;
        int           sent;
        int           n;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_self_x      = '0;
        i_self_y      = '0;
        i_nbr_x       = '0;
        i_nbr_y       = '0;
        i_last_nbr    = 1'b0;
        near_x        = '0;
        near_y        = '0;
        near_dist     = '0;
        near_seen     = 1'b0;
        mismatches    = 0;
        stall_cycles  = 0;
        holds_asked   = 0;
        holds_done    = 0;
        src_idle_pct  = 7;
        sink_idle_pct = 68;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            it.sx      = CB'(dir_tab[k][0]);
            it.sy      = CB'(dir_tab[k][1]);
            it.nx      = CB'(dir_tab[k][2]);
            it.ny      = CB'(dir_tab[k][3]);
            it.last    = dir_tab[k][4][0];
            tr.heading = HEAD_W'(dir_tab[k][6]);
            tr.tx      = CB'(dir_tab[k][7]);
            tr.ty      = CB'(dir_tab[k][8]);
            tr.coinc   = dir_tab[k][9][0];
            send_neighbor(it, dir_tab[k][5][0], tr);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 7;
                    sink_idle_pct = 68;
                end
                1: begin
                    src_idle_pct  = 68;
                    sink_idle_pct = 7;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    holds_asked++;
                end
            endcase
            sent = 0;
            while (sent < RUN_ITEMS) begin
                send_random_run(n);
                sent += n;
            end
        end
        i_valid <= 1'b0;

        while (pending_headings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
